// File: hdl/twhdf_pkg.sv
// package: shared types, constants and command/status structs of the duplicate filter
`timescale 1ns / 1ps
package twhdf_pkg;

	// default geometry
	localparam int unsigned MAX_INTERVALS_DEF = 16;
	localparam int unsigned INTERVAL_BITS_DEF = 65536;

	// fixed limits
	localparam int unsigned MAX_CHUNKS    = 64;
	localparam int unsigned BITS_PER_BYTE = 8;

	// field widths
	localparam int unsigned HASH_W   = 64;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned CCOUNT_W = 7;
	localparam int unsigned CBYTES_W = 14;
	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned CFG_DAT_W = 32;

	// divider widths
	localparam int unsigned DVD_W = 64;
	localparam int unsigned DVS_W = 32;
	localparam int unsigned DCNT_W = $clog2(DVD_W);

	// register reset values
	localparam logic [TIME_W-1:0]   PERIOD_RST = 32'd60;
	localparam logic [TIME_W-1:0]   KEEP_RST   = 32'd3600;
	localparam logic [CCOUNT_W-1:0] CCOUNT_RST = 7'd16;
	localparam logic [CBYTES_W-1:0] CBYTES_RST = 14'd512;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PERIOD = 8'd0,
		CFG_KEEP   = 8'd1,
		CFG_CCOUNT = 8'd2,
		CFG_CBYTES = 8'd3
	} cfg_reg_t;

	// result codes
	typedef enum logic [1:0] {
		ST_NEW     = 2'd0,
		ST_DUP     = 2'd1,
		ST_TOO_OLD = 2'd2,
		ST_NO_SLOT = 2'd3
	} status_t;

	// divider operations
	typedef enum logic [1:0] {
		OP_RND = 2'd0,  // event time / period
		OP_LIM = 2'd1,  // interval bits / chunk count
		OP_CHK = 2'd2,  // hash / chunk count
		OP_BIT = 2'd3   // (hash / chunk count) / chunk bits
	} div_op_t;

	// controller states
	typedef enum logic [4:0] {
		S_IDLE,
		S_RND_GO,
		S_RND_WAIT,
		S_MUL,
		S_AGE,
		S_LIM_GO,
		S_LIM_WAIT,
		S_CHK_GO,
		S_CHK_WAIT,
		S_BIT_GO,
		S_BIT_WAIT,
		S_ADDR,
		S_SCAN,
		S_ALLOC,
		S_CLEAR,
		S_READ,
		S_MODIFY,
		S_FINISH
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic    load_item;
		logic    div_start;
		div_op_t div_op;
		logic    mul;
		logic    addr_calc;
		logic    scan_clear;
		logic    scan_step;
		logic    alloc;
		logic    clear_step;
		logic    mem_read;
		logic    mem_write;
		logic    set_status;
		status_t status;
		logic    out_load;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
		logic too_old;
		logic scan_last;
		logic hit;
		logic alloc_ok;
		logic clear_last;
		logic out_free;
	} dp_sts_t;

endpackage

// File: hdl/twhdf_ifs.sv
// interfaces: item, result and configuration channels
`timescale 1ns / 1ps
interface twhdf_item_if;
	logic                             valid;
	logic                             ready;
	logic [twhdf_pkg::HASH_W-1:0]     hash_value;
	logic [twhdf_pkg::TIME_W-1:0]     event_time;
	logic [twhdf_pkg::TIME_W-1:0]     now_time;

	modport source (output valid, hash_value, event_time, now_time, input ready);
	modport sink (input valid, hash_value, event_time, now_time, output ready);
endinterface

interface twhdf_result_if;
	logic       valid;
	logic       ready;
	logic       seen_before;
	logic [1:0] status;

	modport source (output valid, seen_before, status, input ready);
	modport sink (input valid, seen_before, status, output ready);
endinterface

interface twhdf_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [twhdf_pkg::CFG_IDX_W-1:0]     reg_index;
	logic [twhdf_pkg::CFG_DAT_W-1:0]     wdata;

	modport source (output valid, reg_index, wdata, input ready);
	modport sink (input valid, reg_index, wdata, output ready);
endinterface

// File: hdl/twhdf_div.sv
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module twhdf_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [twhdf_pkg::DVD_W-1:0]  dividend,
	input  logic [twhdf_pkg::DVS_W-1:0]  divisor,
	output logic                         busy,
	output logic                         done,
	output logic [twhdf_pkg::DVD_W-1:0]  quot,
	output logic [twhdf_pkg::DVS_W-1:0]  rem
);
	localparam int unsigned DW = twhdf_pkg::DVD_W;
	localparam int unsigned SW = twhdf_pkg::DVS_W;
	localparam int unsigned CW = twhdf_pkg::DCNT_W;

	logic [DW-1:0] quot_q;
	logic [SW-1:0] rem_q;
	logic [SW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [SW:0]   trial;
	logic [SW+1:0] diff;
	logic          ge;

	// trial subtraction
	always_comb begin
		trial = {rem_q, quot_q[DW-1]};
		diff  = {1'b0, trial} - {2'b00, dvs_q};
		ge    = ~diff[SW+1];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operands and partial results
	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[DW-2:0], ge};
			rem_q  <= ge ? diff[SW-1:0] : trial[SW-1:0];
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;
endmodule

// File: hdl/twhdf_ctrl.sv
// controller: sequences division, slot search, allocation and bitmap update
`timescale 1ns / 1ps
module twhdf_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  twhdf_pkg::dp_sts_t   sts,
	output twhdf_pkg::dp_cmd_t   cmd
);
	twhdf_pkg::ctrl_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= twhdf_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.div_op = twhdf_pkg::OP_RND;
		cmd.status = twhdf_pkg::ST_NEW;
		item_ready = 1'b0;
		unique case (state_q)
			twhdf_pkg::S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.load_item = 1'b1;
					state_d       = twhdf_pkg::S_RND_GO;
				end
			end
			twhdf_pkg::S_RND_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = twhdf_pkg::OP_RND;
				state_d       = twhdf_pkg::S_RND_WAIT;
			end
			twhdf_pkg::S_RND_WAIT: begin
				if (sts.div_done) state_d = twhdf_pkg::S_MUL;
			end
			twhdf_pkg::S_MUL: begin
				cmd.mul = 1'b1;
				state_d = twhdf_pkg::S_AGE;
			end
			twhdf_pkg::S_AGE: begin
				if (sts.too_old) begin
					cmd.set_status = 1'b1;
					cmd.status     = twhdf_pkg::ST_TOO_OLD;
					state_d        = twhdf_pkg::S_FINISH;
				end else begin
					state_d = twhdf_pkg::S_LIM_GO;
				end
			end
			twhdf_pkg::S_LIM_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = twhdf_pkg::OP_LIM;
				state_d       = twhdf_pkg::S_LIM_WAIT;
			end
			twhdf_pkg::S_LIM_WAIT: begin
				if (sts.div_done) state_d = twhdf_pkg::S_CHK_GO;
			end
			twhdf_pkg::S_CHK_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = twhdf_pkg::OP_CHK;
				state_d       = twhdf_pkg::S_CHK_WAIT;
			end
			twhdf_pkg::S_CHK_WAIT: begin
				if (sts.div_done) state_d = twhdf_pkg::S_BIT_GO;
			end
			twhdf_pkg::S_BIT_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = twhdf_pkg::OP_BIT;
				state_d       = twhdf_pkg::S_BIT_WAIT;
			end
			twhdf_pkg::S_BIT_WAIT: begin
				if (sts.div_done) state_d = twhdf_pkg::S_ADDR;
			end
			twhdf_pkg::S_ADDR: begin
				cmd.addr_calc  = 1'b1;
				cmd.scan_clear = 1'b1;
				state_d        = twhdf_pkg::S_SCAN;
			end
			twhdf_pkg::S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) state_d = twhdf_pkg::S_ALLOC;
			end
			twhdf_pkg::S_ALLOC: begin
				cmd.alloc = 1'b1;
				if (sts.hit) begin
					state_d = twhdf_pkg::S_READ;
				end else if (sts.alloc_ok) begin
					state_d = twhdf_pkg::S_CLEAR;
				end else begin
					cmd.set_status = 1'b1;
					cmd.status     = twhdf_pkg::ST_NO_SLOT;
					state_d        = twhdf_pkg::S_FINISH;
				end
			end
			twhdf_pkg::S_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.clear_last) state_d = twhdf_pkg::S_READ;
			end
			twhdf_pkg::S_READ: begin
				cmd.mem_read = 1'b1;
				state_d      = twhdf_pkg::S_MODIFY;
			end
			twhdf_pkg::S_MODIFY: begin
				cmd.mem_write = 1'b1;
				state_d       = twhdf_pkg::S_FINISH;
			end
			twhdf_pkg::S_FINISH: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = twhdf_pkg::S_IDLE;
				end
			end
			default: state_d = twhdf_pkg::S_IDLE;
		endcase
	end
endmodule

// File: hdl/twhdf_dp.sv
// datapath: config registers, divider, slot table, bitmap memory and result register
`timescale 1ns / 1ps
module twhdf_dp #(
	parameter int unsigned MAX_INTERVALS = twhdf_pkg::MAX_INTERVALS_DEF,
	parameter int unsigned INTERVAL_BITS = twhdf_pkg::INTERVAL_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  twhdf_pkg::dp_cmd_t                cmd,
	output twhdf_pkg::dp_sts_t                sts,
	input  logic [twhdf_pkg::HASH_W-1:0]      hash_value,
	input  logic [twhdf_pkg::TIME_W-1:0]      event_time,
	input  logic [twhdf_pkg::TIME_W-1:0]      now_time,
	input  logic                              cfg_write,
	input  logic [twhdf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [twhdf_pkg::CFG_DAT_W-1:0]   cfg_data,
	input  logic                              res_ready,
	output logic                              res_valid,
	output logic                              res_seen,
	output logic [1:0]                        res_status
);
	localparam int unsigned TW         = twhdf_pkg::TIME_W;
	localparam int unsigned SLOT_W     = $clog2(MAX_INTERVALS);
	localparam int unsigned SLOT_WORDS = (INTERVAL_BITS + 63) / 64;
	localparam int unsigned WORD_W     = (SLOT_WORDS > 1) ? $clog2(SLOT_WORDS) : 1;
	localparam int unsigned MEM_DEPTH  = MAX_INTERVALS * (2 ** WORD_W);
	localparam int unsigned BIT_W      = $clog2(INTERVAL_BITS);
	localparam int unsigned CB_W       = $clog2(INTERVAL_BITS + 1);

	// configuration registers
	logic [TW-1:0]                       period_q;
	logic [TW-1:0]                       keep_q;
	logic [twhdf_pkg::CCOUNT_W-1:0]      ccount_q;
	logic [twhdf_pkg::CBYTES_W-1:0]      cbytes_q;

	// item registers
	logic [twhdf_pkg::HASH_W-1:0]        hash_q;
	logic [TW-1:0]                       ev_q;
	logic [TW-1:0]                       now_q;

	// intermediate results
	logic [TW-1:0]                       rq_q;
	logic [TW-1:0]                       rnd_q;
	logic [CB_W-1:0]                     lim_q;
	logic [twhdf_pkg::HASH_W-1:0]        qh_q;
	logic [5:0]                          chunk_q;
	logic [BIT_W-1:0]                    inner_q;
	logic [BIT_W-1:0]                    bit_q;
	twhdf_pkg::div_op_t                  div_op_q;

	// slot table
	logic [MAX_INTERVALS-1:0]            slot_valid_q;
	logic [TW-1:0]                       slot_start_q [MAX_INTERVALS];
	logic [SLOT_W-1:0]                   scan_idx_q;
	logic                                hit_q;
	logic [SLOT_W-1:0]                   hit_idx_q;
	logic                                old_found_q;
	logic [SLOT_W-1:0]                   old_idx_q;
	logic [TW-1:0]                       old_start_q;
	logic                                free_found_q;
	logic [SLOT_W-1:0]                   free_idx_q;
	logic [SLOT_W-1:0]                   slot_q;
	logic [WORD_W-1:0]                   clr_idx_q;

	// bitmap memory
	logic [63:0]                         mem [MEM_DEPTH];
	logic [63:0]                         rd_q;
	twhdf_pkg::status_t                  status_q;

	// result register
	logic                                res_valid_q;
	twhdf_pkg::status_t                  res_status_q;

	// divider interface
	logic                                div_busy;
	logic                                div_done;
	logic [twhdf_pkg::DVD_W-1:0]         div_quot;
	logic [twhdf_pkg::DVS_W-1:0]         div_rem;
	logic [twhdf_pkg::DVD_W-1:0]         div_dvd;
	logic [twhdf_pkg::DVS_W-1:0]         div_dvs;

	// effective geometry and times
	logic [TW-1:0]                       period_eff;
	logic [twhdf_pkg::CCOUNT_W-1:0]      cc_eff;
	logic [31:0]                         cb_raw;
	logic [31:0]                         cb_eff;
	logic [63:0]                         rnd_prod;
	logic [31:0]                         bit_sum;
	logic                                too_old;
	logic                                evict;
	logic                                use_free;
	logic                                alloc_ok;
	logic [SLOT_W-1:0]                   new_slot;
	logic [WORD_W-1:0]                   word_idx;
	logic [SLOT_W+WORD_W-1:0]            mem_addr;
	logic [63:0]                         bit_mask;
	logic                                cur_valid;
	logic [TW-1:0]                       cur_start;

	// clamped configuration
	always_comb begin
		period_eff = (period_q == '0) ? TW'(1) : period_q;
		if (ccount_q == '0) begin
			cc_eff = twhdf_pkg::CCOUNT_W'(1);
		end else if (ccount_q > twhdf_pkg::CCOUNT_W'(twhdf_pkg::MAX_CHUNKS)) begin
			cc_eff = twhdf_pkg::CCOUNT_W'(twhdf_pkg::MAX_CHUNKS);
		end else begin
			cc_eff = ccount_q;
		end
		cb_raw = 32'((cbytes_q == '0) ? twhdf_pkg::CBYTES_W'(1) : cbytes_q)
			* 32'(twhdf_pkg::BITS_PER_BYTE);
		cb_eff = (cb_raw > 32'(lim_q)) ? 32'(lim_q) : cb_raw;
	end

	// divider operand select
	always_comb begin
		case (cmd.div_op)
			twhdf_pkg::OP_RND: begin
				div_dvd = 64'(ev_q);
				div_dvs = period_eff;
			end
			twhdf_pkg::OP_LIM: begin
				div_dvd = 64'(INTERVAL_BITS);
				div_dvs = 32'(cc_eff);
			end
			twhdf_pkg::OP_CHK: begin
				div_dvd = hash_q;
				div_dvs = 32'(cc_eff);
			end
			default: begin
				div_dvd = qh_q;
				div_dvs = cb_eff;
			end
		endcase
	end

	twhdf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// age and eviction checks, allocation choice
	always_comb begin
		rnd_prod  = {32'b0, rq_q} * {32'b0, period_eff};
		bit_sum   = 32'(chunk_q) * cb_eff + 32'(inner_q);
		too_old   = ({1'b0, rnd_q} + {1'b0, keep_q}) < {1'b0, now_q};
		evict     = !hit_q && old_found_q && (old_start_q < rnd_q)
			&& (({2'b0, old_start_q} + {2'b0, period_eff} + {2'b0, keep_q})
			< {2'b0, now_q});
		use_free  = free_found_q && (!evict || free_idx_q < old_idx_q);
		alloc_ok  = use_free || evict;
		new_slot  = use_free ? free_idx_q : old_idx_q;
		word_idx  = WORD_W'(bit_q >> 6);
		mem_addr  = cmd.clear_step ? {slot_q, clr_idx_q} : {slot_q, word_idx};
		bit_mask  = 64'd1 << bit_q[5:0];
		cur_valid = slot_valid_q[scan_idx_q];
		cur_start = slot_start_q[scan_idx_q];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= twhdf_pkg::PERIOD_RST;
			keep_q   <= twhdf_pkg::KEEP_RST;
			ccount_q <= twhdf_pkg::CCOUNT_RST;
			cbytes_q <= twhdf_pkg::CBYTES_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				twhdf_pkg::CFG_PERIOD: period_q <= cfg_data;
				twhdf_pkg::CFG_KEEP:   keep_q   <= cfg_data;
				twhdf_pkg::CFG_CCOUNT: ccount_q <= cfg_data[twhdf_pkg::CCOUNT_W-1:0];
				twhdf_pkg::CFG_CBYTES: cbytes_q <= cfg_data[twhdf_pkg::CBYTES_W-1:0];
				default: ;
			endcase
		end
	end

	// item capture, division results, address
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			hash_q <= hash_value;
			ev_q   <= event_time;
			now_q  <= now_time;
		end
		if (cmd.div_start) div_op_q <= cmd.div_op;
		if (div_done) begin
			case (div_op_q)
				twhdf_pkg::OP_RND: rq_q <= div_quot[TW-1:0];
				twhdf_pkg::OP_LIM: lim_q <= div_quot[CB_W-1:0];
				twhdf_pkg::OP_CHK: begin
					qh_q    <= div_quot;
					chunk_q <= div_rem[5:0];
				end
				default: inner_q <= div_rem[BIT_W-1:0];
			endcase
		end
		if (cmd.mul) rnd_q <= rnd_prod[TW-1:0];
		if (cmd.addr_calc) bit_q <= bit_sum[BIT_W-1:0];
	end

	// slot scan: match, oldest valid slot, first free slot
	always_ff @(posedge clk) begin
		if (cmd.scan_clear) begin
			scan_idx_q   <= '0;
			hit_q        <= 1'b0;
			old_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end else if (cmd.scan_step) begin
			scan_idx_q <= scan_idx_q + 1'b1;
			if (cur_valid && cur_start == rnd_q && !hit_q) begin
				hit_q     <= 1'b1;
				hit_idx_q <= scan_idx_q;
			end
			if (cur_valid && (!old_found_q || cur_start < old_start_q)) begin
				old_found_q <= 1'b1;
				old_idx_q   <= scan_idx_q;
				old_start_q <= cur_start;
			end
			if (!cur_valid && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= scan_idx_q;
			end
		end
		if (cmd.alloc) begin
			slot_q    <= hit_q ? hit_idx_q : new_slot;
			clr_idx_q <= '0;
			if (!hit_q && alloc_ok) slot_start_q[new_slot] <= rnd_q;
		end else if (cmd.clear_step) begin
			clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	// slot valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
		end else if (cmd.alloc && !hit_q && alloc_ok) begin
			if (evict) slot_valid_q[old_idx_q] <= 1'b0;
			slot_valid_q[new_slot] <= 1'b1;
		end
	end

	// bitmap memory: clear sweep, read, set bit
	always_ff @(posedge clk) begin
		if (cmd.clear_step) begin
			mem[mem_addr] <= '0;
		end else if (cmd.mem_write) begin
			mem[mem_addr] <= rd_q | bit_mask;
		end
		if (cmd.mem_read) rd_q <= mem[mem_addr];
	end

	// item status
	always_ff @(posedge clk) begin
		if (cmd.set_status) begin
			status_q <= cmd.status;
		end else if (cmd.mem_write) begin
			status_q <= ((rd_q & bit_mask) != '0) ? twhdf_pkg::ST_DUP : twhdf_pkg::ST_NEW;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) res_status_q <= status_q;
	end

	assign res_valid  = res_valid_q;
	assign res_status = res_status_q;
	assign res_seen   = (res_status_q == twhdf_pkg::ST_DUP);

	// status to controller
	always_comb begin
		sts            = '0;
		sts.div_done   = div_done;
		sts.too_old    = too_old;
		sts.scan_last  = (scan_idx_q == SLOT_W'(MAX_INTERVALS - 1));
		sts.hit        = hit_q;
		sts.alloc_ok   = alloc_ok;
		sts.clear_last = (clr_idx_q == WORD_W'(SLOT_WORDS - 1));
		sts.out_free   = !res_valid_q || res_ready;
	end

`ifndef ASSERT_OFF
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !div_busy)
		else $error("divider started while busy");
	a_clear_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_step |-> slot_valid_q[slot_q])
		else $error("clearing a slot that is not allocated");
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.clear_step && (cmd.mem_write || cmd.mem_read)))
		else $error("bitmap access during clear sweep");
	a_slot_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(slot_valid_q) + 1 >= $past($countones(slot_valid_q)))
		else $error("more than one slot freed at once");
`endif
endmodule

// File: hdl/time_windowed_hash_duplicate_filter.sv
// top level: time-bucketed bitmap duplicate filter
//
//  channel  dir  handshake      payload
//  item     in   valid/ready    hash_value[63:0], event_time[31:0], now_time[31:0]
//  result   out  valid/ready    seen_before, status[1:0]
//  cfg      in   valid/ready    reg_index[7:0], wdata[31:0] (ready always high)
//
// one item at a time; divisions on the shared divider set most of the time: one for a
// too-old item, four of a 64-bit dividend for an item in a known interval.
// a new interval adds a clear sweep of ceil(INTERVAL_BITS/64) words over the bitmap memory.
// reset clears control state, slot valid bits, config registers and result valid; no memory sweep after reset.
// a result waiting on a stalled sink does not block the next item until that item finishes.
`timescale 1ns / 1ps
module time_windowed_hash_duplicate_filter #(
	parameter int unsigned MAX_INTERVALS = twhdf_pkg::MAX_INTERVALS_DEF,
	parameter int unsigned INTERVAL_BITS = twhdf_pkg::INTERVAL_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	twhdf_item_if.sink         item,
	twhdf_result_if.source     result,
	twhdf_cfg_if.sink          cfg
);
	twhdf_pkg::dp_cmd_t cmd;
	twhdf_pkg::dp_sts_t sts;
	logic               in_ready;

	// controller
	twhdf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (in_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	// datapath
	twhdf_dp #(
		.MAX_INTERVALS (MAX_INTERVALS),
		.INTERVAL_BITS (INTERVAL_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.hash_value (item.hash_value),
		.event_time (item.event_time),
		.now_time   (item.now_time),
		.cfg_write  (cfg.valid),
		.cfg_index  (cfg.reg_index),
		.cfg_data   (cfg.wdata),
		.res_ready  (result.ready),
		.res_valid  (result.valid),
		.res_seen   (result.seen_before),
		.res_status (result.status)
	);

	// handshake outputs
	assign item.ready = in_ready;
	assign cfg.ready  = 1'b1;
endmodule

// File: test/time_windowed_hash_duplicate_filter_tb.sv
// testbench: predicts and checks the time-bucketed duplicate filter under random handshakes
`timescale 1ns / 1ps
module time_windowed_hash_duplicate_filter_tb;

	localparam int unsigned SLOTS = twhdf_pkg::MAX_INTERVALS_DEF;
	localparam int unsigned WORDS = (twhdf_pkg::INTERVAL_BITS_DEF + 63) / 64;

	typedef struct {
		bit                 seen;
		twhdf_pkg::status_t status;
	} verdict_t;

	// duplicate filter predictor and queue of expected verdicts
	class dup_scoreboard;
		bit [31:0]  period_r, keep_r;
		bit [6:0]   ccount_r;
		bit [13:0]  cbytes_r;
		bit         slot_used [SLOTS];
		bit [31:0]  slot_begin [SLOTS];
		bit [63:0]  bitmap [SLOTS][WORDS];
		verdict_t   verdicts [$];
		int         mismatches;

		function new();
			period_r = twhdf_pkg::PERIOD_RST;
			keep_r = twhdf_pkg::KEEP_RST;
			ccount_r = twhdf_pkg::CCOUNT_RST;
			cbytes_r = twhdf_pkg::CBYTES_RST;
			mismatches = 0;
			foreach (slot_used[i]) slot_used[i] = 0;
		endfunction

		function void write_reg(twhdf_pkg::cfg_reg_t idx, bit [31:0] data);
			case (idx)
				twhdf_pkg::CFG_PERIOD: period_r = data;
				twhdf_pkg::CFG_KEEP:   keep_r = data;
				twhdf_pkg::CFG_CCOUNT: ccount_r = data[6:0];
				twhdf_pkg::CFG_CBYTES: cbytes_r = data[13:0];
				default: ;
			endcase
		endfunction

		function bit [31:0] period_eff();
			return (period_r == 0) ? 32'd1 : period_r;
		endfunction

		// compute the verdict of one accepted transaction and update the bitmap
		function void note_item(bit [63:0] hash, bit [31:0] ev, bit [31:0] now);
			bit [31:0] per, rnd;
			longint unsigned cc, cb, chunk, inner, bitpos;
			longint lim;
			int slot, oldest;
			verdict_t v;
			per = period_eff();
			cc = (ccount_r == 0) ? 1 : ((ccount_r > twhdf_pkg::MAX_CHUNKS) ?
				twhdf_pkg::MAX_CHUNKS : ccount_r);
			cb = ((cbytes_r == 0) ? 1 : cbytes_r) * twhdf_pkg::BITS_PER_BYTE;
			if (cb > twhdf_pkg::INTERVAL_BITS_DEF / cc) cb = twhdf_pkg::INTERVAL_BITS_DEF / cc;
			if (cb == 0) cb = 1;
			rnd = (ev / per) * per;
			lim = longint'(now) - longint'(keep_r);
			slot = -1;
			v.seen = 0;
			if (longint'(rnd) < lim) begin
				v.status = twhdf_pkg::ST_TOO_OLD;
				verdicts.push_back(v);
				return;
			end
			for (int i = 0; i < SLOTS; i++)
				if (slot < 0 && slot_used[i] && slot_begin[i] == rnd) slot = i;
			if (slot < 0) begin
				oldest = -1;
				for (int i = 0; i < SLOTS; i++)
					if (slot_used[i] && (oldest < 0 || slot_begin[i] < slot_begin[oldest]))
						oldest = i;
				if (oldest >= 0 && slot_begin[oldest] < rnd &&
				    longint'(slot_begin[oldest]) + longint'(per) < lim)
					slot_used[oldest] = 0;
				for (int i = 0; i < SLOTS; i++)
					if (slot < 0 && !slot_used[i]) slot = i;
				if (slot < 0) begin
					v.status = twhdf_pkg::ST_NO_SLOT;
					verdicts.push_back(v);
					return;
				end
				slot_used[slot] = 1;
				slot_begin[slot] = rnd;
				for (int w = 0; w < WORDS; w++) bitmap[slot][w] = '0;
			end
			chunk = hash % cc;
			inner = (hash / cc) % cb;
			bitpos = chunk * cb + inner;
			if (bitpos >= WORDS * 64) bitpos = 0;
			v.seen = bitmap[slot][bitpos >> 6][bitpos[5:0]];
			bitmap[slot][bitpos >> 6][bitpos[5:0]] = 1'b1;
			v.status = v.seen ? twhdf_pkg::ST_DUP : twhdf_pkg::ST_NEW;
			verdicts.push_back(v);
		endfunction

		// compare one result transaction with the oldest expected verdict
		function void check(bit seen, bit [1:0] status);
			verdict_t v;
			if (verdicts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: seen_before=%0d status=%0d", seen, status);
				return;
			end
			v = verdicts[0];
			verdicts.delete(0);
			if (seen !== v.seen || status !== v.status) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected seen_before=%0d status=%0d, got %0d %0d",
						v.seen, v.status, seen, status);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	twhdf_item_if   item ();
	twhdf_result_if result ();
	twhdf_cfg_if    cfg ();
	dup_scoreboard  sb;
	bit [31:0]      cur_now;
	bit [63:0]      hash_pool [8];

	time_windowed_hash_duplicate_filter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item.source),
		.result (result.sink),
		.cfg    (cfg.source)
	);

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// give up after a generous time
	initial begin
		#200ms;
		$display("FAIL");
		$finish;
	end

	// send one item transaction after a random gap
	task automatic send_item(bit [63:0] h, bit [31:0] ev, bit [31:0] now);
		int gap;
		gap = $urandom_range(0, 3);
		if (gap > 0) begin
			item.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item.valid <= 1'b1;
		item.hash_value <= h;
		item.event_time <= ev;
		item.now_time <= now;
		do @(posedge clk); while (!item.ready);
		sb.note_item(h, ev, now);
	endtask

	// one register write transaction, valid stays up for back-to-back writes
	task automatic write_reg(twhdf_pkg::cfg_reg_t idx, bit [31:0] data);
		cfg.valid <= 1'b1;
		cfg.reg_index <= idx;
		cfg.wdata <= data;
		do @(posedge clk); while (!cfg.ready);
		sb.write_reg(idx, data);
	endtask

	// wait until every verdict has arrived and the block is idle
	task automatic drain();
		item.valid <= 1'b0;
		while (sb.verdicts.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_config(bit [31:0] per, bit [31:0] keep, bit [31:0] cc, bit [31:0] cb);
		drain();
		write_reg(twhdf_pkg::CFG_PERIOD, per);
		write_reg(twhdf_pkg::CFG_KEEP, keep);
		write_reg(twhdf_pkg::CFG_CCOUNT, cc);
		write_reg(twhdf_pkg::CFG_CBYTES, cb);
		cfg.valid <= 1'b0;
	endtask

	// mostly items near the current time with recurring hashes, some noise
	task automatic random_items(int count);
		bit [63:0] h, pe, off;
		bit [31:0] ev;
		int pick;
		for (int n = 0; n < count; n++) begin
			pe = sb.period_eff();
			if ($urandom_range(0, 15) == 0) cur_now = cur_now + pe * $urandom_range(1, 3);
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 1)) h = hash_pool[$urandom_range(0, 7)];
			else h = {$urandom, $urandom};
			off = pe * $urandom_range(0, 3) + $urandom_range(0, (pe > 1000) ? 1000 : pe - 1);
			ev = cur_now - off;
			if (pick < 10) begin
				send_item({$urandom, $urandom}, $urandom, $urandom);
			end else if (pick < 15) begin
				send_item(h, cur_now - sb.keep_r - pe * 4 - $urandom_range(1, 50), cur_now);
			end else begin
				send_item(h, ev, cur_now);
			end
		end
	endtask

	// result side: random stalls, check every transaction
	initial begin
		int gap;
		result.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = $urandom_range(0, 3);
			if (gap > 0) begin
				result.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result.ready <= 1'b1;
			do @(posedge clk); while (!result.valid);
			sb.check(result.seen_before, result.status);
		end
	end

	// stimulus
	initial begin
		int waited;
		sb = new();
		foreach (hash_pool[i]) hash_pool[i] = {$urandom, $urandom};
		hash_pool[0] = '0;
		hash_pool[1] = '1;
		item.valid = 1'b0;
		item.hash_value = '0;
		item.event_time = '0;
		item.now_time = '0;
		cfg.valid = 1'b0;
		cfg.reg_index = twhdf_pkg::CFG_PERIOD;
		cfg.wdata = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: new, duplicate, hash extremes, too old
		cur_now = 32'd100000;
		send_item(64'd5, cur_now, cur_now);
		send_item(64'd5, cur_now, cur_now);
		send_item('0, cur_now, cur_now);
		send_item('1, cur_now, cur_now);
		send_item('1, cur_now, cur_now);
		send_item(64'd9, 32'd0, cur_now);
		send_item(64'd9, '1, '1);
		// fill every slot, then the last two intervals find no slot
		for (int i = 1; i <= 16; i++) send_item(64'd7, cur_now - i * 60, cur_now);
		// far later time lets the oldest interval expire and be evicted
		cur_now = cur_now + 4000;
		send_item(64'd7, cur_now, cur_now);
		send_item(64'd7, cur_now, cur_now);
		random_items(300);

		// register extremes and out-of-range cases
		set_config(32'd1, 32'd0, 32'd1, 32'd1);
		random_items(250);
		set_config('1, '1, 32'd64, 32'd8192);
		cur_now = $urandom;
		random_items(250);
		set_config(32'd0, 32'd5, 32'd0, 32'd0);
		random_items(250);
		set_config(32'd7, 32'd100, 32'd127, 32'd16383);
		random_items(250);
		set_config($urandom_range(1, 1000), $urandom_range(0, 20000),
			$urandom_range(1, 64), $urandom_range(1, 8192));
		random_items(250);
		set_config(twhdf_pkg::PERIOD_RST, twhdf_pkg::KEEP_RST, twhdf_pkg::CCOUNT_RST,
			twhdf_pkg::CBYTES_RST);
		random_items(280);

		// finish
		item.valid <= 1'b0;
		waited = 0;
		while (sb.verdicts.size() != 0 && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		repeat (100) @(posedge clk);
		if (sb.mismatches == 0 && sb.verdicts.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
